@@ src/dual_breathing_led_duty_sequencer_core_assert.svh @@
// Assertion macros for the dual breathing LED duty sequencer.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef DUAL_BREATHING_LED_DUTY_SEQUENCER_CORE_ASSERT_SVH
`define DUAL_BREATHING_LED_DUTY_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DBLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define DBLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/dbls_pkg.sv @@
// Shared types, constants and duty functions for the breathing LED sequencer.
// No dependencies.
package dbls_pkg;

  localparam int PHASE_BITS = 16;
  localparam int DIV_BITS   = 8;
  localparam int PEAK_BITS  = 15;
  localparam int DUTY_BITS  = 9;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  typedef logic [PHASE_BITS-1:0] phase_t;
  typedef logic [DIV_BITS-1:0]   div_t;
  typedef logic [PEAK_BITS-1:0]  peak_t;
  typedef logic [DUTY_BITS-1:0]  duty_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TICKS_PER_STEP = 3'd0,
    CFG_CYCLE_LENGTH   = 3'd1,
    CFG_RAMP_PEAK      = 3'd2,
    CFG_START_DELAY    = 3'd3,
    CFG_FIRST_PASS_END = 3'd4
  } cfg_idx_t;

  localparam div_t   RST_TICKS_PER_STEP = 8'd100;
  localparam phase_t RST_CYCLE_LENGTH   = 16'd950;
  localparam peak_t  RST_RAMP_PEAK      = 15'd275;
  localparam phase_t RST_START_DELAY    = 16'd450;
  localparam phase_t RST_FIRST_PASS_END = 16'd1350;

  // Widths above 255 fold: high = (w/255) & 1, low = (w-255) & 0xFF.
  // w/255 is exact as ((w+1)*257) >> 16 for 16-bit w; low is (w+1) & 0xFF.
  function automatic duty_t encode_duty(input phase_t w);
    logic [PHASE_BITS:0]   wp1;
    logic [PHASE_BITS+8:0] prod;
    wp1  = {1'b0, w} + (PHASE_BITS+1)'(1);
    prod = {wp1, 8'd0} + {8'd0, wp1};
    if (w > phase_t'(255)) begin
      return {prod[16], wp1[7:0]};
    end
    return {1'b0, w[7:0]};
  endfunction

  // Rise to the peak, fall to zero at twice the peak, hold beyond.
  function automatic duty_t triangle(input phase_t ph, input duty_t held, input peak_t peak);
    phase_t pk;
    phase_t top;
    pk  = phase_t'(peak);
    top = phase_t'({peak, 1'b0});
    if (ph < pk) begin
      return encode_duty(ph);
    end
    if (ph <= top) begin
      return encode_duty(top - ph);
    end
    return held;
  endfunction

endpackage

@@ src/dbls_if.sv @@
// Valid/ready channel interfaces for the breathing LED sequencer.
// Depends on dbls_pkg.
interface dbls_in_if;
  logic valid;
  logic ready;
  logic tick;
  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface dbls_out_if;
  logic valid;
  logic ready;
  logic duty_a_high;
  logic [7:0] duty_a_low;
  logic duty_b_high;
  logic [7:0] duty_b_low;
  logic duty_updated;
  modport source (output valid, output duty_a_high, output duty_a_low,
                  output duty_b_high, output duty_b_low, output duty_updated,
                  input ready);
  modport sink   (input valid, input duty_a_high, input duty_a_low,
                  input duty_b_high, input duty_b_low, input duty_updated,
                  output ready);
endinterface

interface dbls_cfg_if;
  logic valid;
  logic ready;
  logic [dbls_pkg::CFG_IDX_BITS-1:0]  index;
  logic [dbls_pkg::CFG_DATA_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/dual_breathing_led_duty_sequencer_core.sv @@
// Dual breathing LED duty sequencer: tick divider, two phase counters, triangle duty.
// Depends on dbls_pkg, dbls_if and dual_breathing_led_duty_sequencer_core_assert.svh.
// Throughput: one tick per cycle unless the output stalls (out_ch.ready low).
// The state update loop is a single registered stage, fed by the input stage.
// Reset (rst_n low, synchronous): config back to defaults, counters zero, first pass
//   set, held duties zero, both pipeline stages empty.
`include "dual_breathing_led_duty_sequencer_core_assert.svh"

module dual_breathing_led_duty_sequencer_core (
  input logic      clk,
  input logic      rst_n,
  dbls_in_if.sink  in_ch,
  dbls_out_if.source out_ch,
  dbls_cfg_if.sink cfg_ch
);

  // Config registers
  dbls_pkg::div_t   ticks_per_step_r;
  dbls_pkg::phase_t cycle_length_r;
  dbls_pkg::peak_t  ramp_peak_r;
  dbls_pkg::phase_t start_delay_r;
  dbls_pkg::phase_t first_pass_end_r;

  // Input stage
  logic s1_valid_r;
  logic tick_r;

  // Sequencer state
  dbls_pkg::div_t   tick_divider_r, tick_divider_nxt;
  dbls_pkg::phase_t phase_a_r, phase_a_nxt;
  dbls_pkg::phase_t phase_b_r, phase_b_nxt;
  dbls_pkg::phase_t shifted_b_r, shifted_b_nxt;
  logic             first_pass_r, first_pass_nxt;
  dbls_pkg::duty_t  held_a_r, held_a_nxt;
  dbls_pkg::duty_t  held_b_r, held_b_nxt;

  // Result stage: payload is the held duties plus the update flag
  logic out_valid_r;
  logic updated_r, updated_nxt;

  logic advance;
  logic in_ready;

  // Stage 1 moves into the result register when that slot is free or draining.
  assign advance  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.duty_a_high  = held_a_r[8];
  assign out_ch.duty_a_low   = held_a_r[7:0];
  assign out_ch.duty_b_high  = held_b_r[8];
  assign out_ch.duty_b_low   = held_b_r[7:0];
  assign out_ch.duty_updated = updated_r;

  // One tick of the sequencer, in the order the phases are checked and bumped.
  always_comb begin
    tick_divider_nxt = tick_divider_r;
    phase_a_nxt      = phase_a_r;
    phase_b_nxt      = phase_b_r;
    shifted_b_nxt    = shifted_b_r;
    first_pass_nxt   = first_pass_r;
    held_a_nxt       = held_a_r;
    held_b_nxt       = held_b_r;
    updated_nxt      = 1'b0;
    if (tick_r) begin
      // first pass ends on the old phase B value
      if (phase_b_r == first_pass_end_r) begin
        first_pass_nxt = 1'b0;
      end
      if (phase_a_r == cycle_length_r) begin
        phase_a_nxt = '0;
      end
      // phase B only wraps at cycle length once free-running
      if (!first_pass_nxt && phase_b_r == cycle_length_r) begin
        phase_b_nxt = '0;
      end
      if (tick_divider_r == ticks_per_step_r) begin
        tick_divider_nxt = '0;
        phase_a_nxt      = phase_a_nxt + dbls_pkg::PHASE_BITS'(1);
        phase_b_nxt      = phase_b_nxt + dbls_pkg::PHASE_BITS'(1);
      end
      // duties refresh whenever the divider sits at zero
      if (tick_divider_nxt == '0) begin
        updated_nxt = 1'b1;
        held_a_nxt  = dbls_pkg::triangle(phase_a_nxt, held_a_r, ramp_peak_r);
        if (first_pass_nxt) begin
          // before the start delay, shifted B keeps its last value
          if (phase_b_nxt >= start_delay_r) begin
            shifted_b_nxt = phase_b_nxt - start_delay_r;
          end
        end else begin
          shifted_b_nxt = phase_b_nxt;
        end
        held_b_nxt = dbls_pkg::triangle(shifted_b_nxt, held_b_r, ramp_peak_r);
      end
      tick_divider_nxt = tick_divider_nxt + dbls_pkg::DIV_BITS'(1);
    end
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_per_step_r <= dbls_pkg::RST_TICKS_PER_STEP;
      cycle_length_r   <= dbls_pkg::RST_CYCLE_LENGTH;
      ramp_peak_r      <= dbls_pkg::RST_RAMP_PEAK;
      start_delay_r    <= dbls_pkg::RST_START_DELAY;
      first_pass_end_r <= dbls_pkg::RST_FIRST_PASS_END;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        dbls_pkg::CFG_TICKS_PER_STEP: ticks_per_step_r <= cfg_ch.data[7:0];
        dbls_pkg::CFG_CYCLE_LENGTH:   cycle_length_r   <= cfg_ch.data;
        dbls_pkg::CFG_RAMP_PEAK:      ramp_peak_r      <= cfg_ch.data[14:0];
        dbls_pkg::CFG_START_DELAY:    start_delay_r    <= cfg_ch.data;
        dbls_pkg::CFG_FIRST_PASS_END: first_pass_end_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      tick_r <= in_ch.tick;
    end
  end

  // State and result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      updated_r      <= 1'b0;
      tick_divider_r <= '0;
      phase_a_r      <= '0;
      phase_b_r      <= '0;
      shifted_b_r    <= '0;
      first_pass_r   <= 1'b1;
      held_a_r       <= '0;
      held_b_r       <= '0;
    end else begin
      if (advance) begin
        out_valid_r    <= 1'b1;
        updated_r      <= updated_nxt;
        tick_divider_r <= tick_divider_nxt;
        phase_a_r      <= phase_a_nxt;
        phase_b_r      <= phase_b_nxt;
        shifted_b_r    <= shifted_b_nxt;
        first_pass_r   <= first_pass_nxt;
        held_a_r       <= held_a_nxt;
        held_b_r       <= held_b_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Checks
  `DBLS_ASSERT_NEXT(a_fp_sticky, !first_pass_r, !first_pass_r, "first pass came back")
  `DBLS_ASSERT_NEXT(a_adv_fills, advance, out_valid_r, "result beat lost")
  `DBLS_ASSERT_NEXT(a_div_restart, advance && tick_r && tick_divider_r == ticks_per_step_r,
    tick_divider_r == dbls_pkg::DIV_BITS'(1), "divider did not restart")
  `DBLS_ASSERT_NEXT(a_idle_hold, advance && !tick_r,
    $stable(phase_a_r) && $stable(tick_divider_r) && !updated_r, "idle beat changed state")

endmodule

@@ test/tb_top.sv @@
// Testbench for dual_breathing_led_duty_sequencer_core: a table of directed tick and
// register beats, then random tick streams under several register settings.
// Depends on dbls_pkg, dbls_if and the core RTL; results match table rows or a duty model.
module tb_top;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int MAX_REPORTS  = 10;
  localparam int HOLD_CYCLES  = 80;
  localparam int TICK_PCT     = 85;
  localparam int DRAIN_CYCLES = 4;

  // Index 5 has no register behind it; a write there must change nothing.
  localparam dbls_pkg::cfg_idx_t CFG_UNUSED = dbls_pkg::cfg_idx_t'(3'd5);

  typedef struct packed {
    logic       a_high;
    logic [7:0] a_low;
    logic       b_high;
    logic [7:0] b_low;
    logic       updated;
  } duty_beat_t;

  localparam duty_beat_t HELD_ZERO    = '0;
  localparam duty_beat_t UPDATED_ZERO = {1'b0, 8'd0, 1'b0, 8'd0, 1'b1};
  localparam duty_beat_t A_STEP_ONE   = {1'b0, 8'd1, 1'b0, 8'd0, 1'b1};

  typedef struct {
    dbls_pkg::div_t   divider;
    dbls_pkg::phase_t phase_a;
    dbls_pkg::phase_t phase_b;
    dbls_pkg::phase_t shifted_b;
    logic             first_pass;
    dbls_pkg::duty_t  held_a;
    dbls_pkg::duty_t  held_b;
  } seq_state_t;

  typedef struct {
    dbls_pkg::div_t   ticks_per_step;
    dbls_pkg::phase_t cycle_length;
    dbls_pkg::peak_t  ramp_peak;
    dbls_pkg::phase_t start_delay;
    dbls_pkg::phase_t first_pass_end;
  } seq_regs_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic               tick;
    dbls_pkg::cfg_idx_t idx;
    logic [15:0]        data;
    logic               typed;
    duty_beat_t         want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dbls_in_if  in_ch ();
  dbls_out_if out_ch ();
  dbls_cfg_if cfg_ch ();

  dual_breathing_led_duty_sequencer_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  seq_state_t seq;
  seq_regs_t  regs;
  duty_beat_t duty_q[$];
  stim_row_t  stim_rows[$];
  int         mismatches = 0;
  int         src_idle_pct = 0;
  int         snk_idle_pct = 0;
  int         hold_req = 0;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------- duty model

  // Widths above 255 fold into a high bit and a wrapped low byte.
  function automatic dbls_pkg::duty_t duty_code(input int unsigned w);
    if (w > 255) begin
      return {1'(w / 255), 8'(w - 255)};
    end
    return {1'b0, 8'(w)};
  endfunction

  // Triangle: rise to the peak, fall to zero at twice the peak, hold beyond.
  function automatic dbls_pkg::duty_t ramp_duty(input dbls_pkg::phase_t ph,
                                                input dbls_pkg::duty_t held);
    int unsigned top;
    top = regs.ramp_peak * 2;
    if (ph < regs.ramp_peak) begin
      return duty_code(32'(ph));
    end
    if (ph <= top) begin
      return duty_code(top - ph);
    end
    return held;
  endfunction

  function automatic void seq_clear();
    regs.ticks_per_step = dbls_pkg::RST_TICKS_PER_STEP;
    regs.cycle_length   = dbls_pkg::RST_CYCLE_LENGTH;
    regs.ramp_peak      = dbls_pkg::RST_RAMP_PEAK;
    regs.start_delay    = dbls_pkg::RST_START_DELAY;
    regs.first_pass_end = dbls_pkg::RST_FIRST_PASS_END;
    seq.divider    = '0;
    seq.phase_a    = '0;
    seq.phase_b    = '0;
    seq.shifted_b  = '0;
    seq.first_pass = 1'b1;
    seq.held_a     = '0;
    seq.held_b     = '0;
  endfunction

  function automatic void regs_write(input dbls_pkg::cfg_idx_t idx, input logic [15:0] val);
    case (idx)
      dbls_pkg::CFG_TICKS_PER_STEP: regs.ticks_per_step = val[7:0];
      dbls_pkg::CFG_CYCLE_LENGTH:   regs.cycle_length   = val;
      dbls_pkg::CFG_RAMP_PEAK:      regs.ramp_peak      = val[14:0];
      dbls_pkg::CFG_START_DELAY:    regs.start_delay    = val;
      dbls_pkg::CFG_FIRST_PASS_END: regs.first_pass_end = val;
      default: ;
    endcase
  endfunction

  // One tick beat: wrap checks first, then the divider step, then the duty refresh.
  function automatic duty_beat_t seq_tick(input logic tick);
    logic upd;
    upd = 1'b0;
    if (tick) begin
      if (seq.phase_b == regs.first_pass_end) seq.first_pass = 1'b0;
      if (seq.phase_a == regs.cycle_length) seq.phase_a = '0;
      if (!seq.first_pass && seq.phase_b == regs.cycle_length) seq.phase_b = '0;
      if (seq.divider == regs.ticks_per_step) begin
        seq.divider = '0;
        seq.phase_a = seq.phase_a + 16'd1;
        seq.phase_b = seq.phase_b + 16'd1;
      end
      if (seq.divider == '0) begin
        upd = 1'b1;
        seq.held_a = ramp_duty(seq.phase_a, seq.held_a);
        // B keeps its old shifted phase while still short of the start delay
        if (!seq.first_pass) begin
          seq.shifted_b = seq.phase_b;
        end else if (seq.phase_b >= regs.start_delay) begin
          seq.shifted_b = seq.phase_b - regs.start_delay;
        end
        seq.held_b = ramp_duty(seq.shifted_b, seq.held_b);
      end
      seq.divider = seq.divider + 8'd1;
    end
    return {seq.held_a[8], seq.held_a[7:0], seq.held_b[8], seq.held_b[7:0], upd};
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void add_beat(input logic tick, input logic typed,
                                   input duty_beat_t want);
    stim_row_t r;
    r.kind  = ROW_BEAT;
    r.tick  = tick;
    r.idx   = dbls_pkg::CFG_TICKS_PER_STEP;
    r.data  = '0;
    r.typed = typed;
    r.want  = want;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input dbls_pkg::cfg_idx_t idx, input logic [15:0] data);
    stim_row_t r;
    r.kind  = ROW_CFG;
    r.tick  = 1'b0;
    r.idx   = idx;
    r.data  = data;
    r.typed = 1'b0;
    r.want  = '0;
    stim_rows.push_back(r);
  endfunction

  // Offer one tick beat; valid stays high afterwards so back-to-back beats need no gap.
  task automatic push_tick(input logic tick, input logic typed, input duty_beat_t want);
    duty_beat_t beat;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.tick  <= tick;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    beat = seq_tick(tick);
    duty_q.push_back(typed ? want : beat);
  endtask

  // Every tick beat yields a result, so an empty queue means the core is idle.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (duty_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input dbls_pkg::cfg_idx_t idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    regs_write(idx, val);
  endtask

  task automatic configure(input logic [15:0] tps, input logic [15:0] cyc,
                           input logic [15:0] peak, input logic [15:0] delay,
                           input logic [15:0] pass_end);
    settle();
    cfg_write(dbls_pkg::CFG_TICKS_PER_STEP, tps);
    cfg_write(dbls_pkg::CFG_CYCLE_LENGTH, cyc);
    cfg_write(dbls_pkg::CFG_RAMP_PEAK, peak);
    cfg_write(dbls_pkg::CFG_START_DELAY, delay);
    cfg_write(dbls_pkg::CFG_FIRST_PASS_END, pass_end);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_ticks(input int beats, input int hold_at);
    int n;
    for (n = 0; n < beats; n++) begin
      if (n == hold_at) hold_req <= hold_req + 1;
      push_tick($urandom_range(0, 99) < TICK_PCT, 1'b0, HELD_ZERO);
    end
  endtask

  // ---------------------------------------------------------------- result side

  // Receiver: random back-pressure, plus a long hold-off on request from the main flow.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : duty_check
    duty_beat_t got;
    duty_beat_t want;
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = {out_ch.duty_a_high, out_ch.duty_a_low, out_ch.duty_b_high,
             out_ch.duty_b_low, out_ch.duty_updated};
      if (duty_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("duty beat with nothing pending: a=%0d/%0d b=%0d/%0d upd=%0d",
                   got.a_high, got.a_low, got.b_high, got.b_low, got.updated);
      end else begin
        want = duty_q.pop_front();
        if (got.a_high !== want.a_high || got.a_low !== want.a_low ||
            got.b_high !== want.b_high || got.b_low !== want.b_low ||
            got.updated !== want.updated) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: want a=%0d/%0d b=%0d/%0d u=%0d, got a=%0d/%0d b=%0d/%0d u=%0d",
                     want.a_high, want.a_low, want.b_high, want.b_low, want.updated,
                     got.a_high, got.a_low, got.b_high, got.b_low, got.updated);
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- main flow

  initial begin : main_flow
    int i;
    seq_clear();
    in_ch.valid  <= 1'b0;
    in_ch.tick   <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= dbls_pkg::CFG_TICKS_PER_STEP;
    cfg_ch.data  <= '0;
    src_idle_pct = 36;
    snk_idle_pct = 63;

    // Directed table. Reset state: divider at zero refreshes on the first tick only.
    add_beat(1'b1, 1'b1, UPDATED_ZERO);
    add_beat(1'b0, 1'b1, HELD_ZERO);          // idle beat holds duties
    add_beat(1'b1, 1'b1, HELD_ZERO);          // divider mid-count, no refresh
    add_cfg(dbls_pkg::CFG_TICKS_PER_STEP, 16'd2);
    add_beat(1'b1, 1'b1, A_STEP_ONE);         // divider match; B still inside start delay
    add_cfg(dbls_pkg::CFG_TICKS_PER_STEP, 16'hFF01);    // upper byte masked off
    add_cfg(dbls_pkg::CFG_CYCLE_LENGTH, 16'd1);
    add_cfg(dbls_pkg::CFG_RAMP_PEAK, 16'hFFFF);         // masked to the 15-bit maximum
    add_cfg(dbls_pkg::CFG_START_DELAY, 16'd0);
    add_cfg(dbls_pkg::CFG_FIRST_PASS_END, 16'hFFFF);
    add_beat(1'b1, 1'b0, HELD_ZERO);
    add_beat(1'b0, 1'b0, HELD_ZERO);
    add_beat(1'b1, 1'b0, HELD_ZERO);
    add_beat(1'b1, 1'b0, HELD_ZERO);
    add_cfg(CFG_UNUSED, 16'hFFFF);
    add_cfg(dbls_pkg::CFG_CYCLE_LENGTH, 16'hFFFF);
    add_cfg(dbls_pkg::CFG_RAMP_PEAK, 16'd1);            // tiny ramp: phases past 2 hold
    add_cfg(dbls_pkg::CFG_START_DELAY, 16'hFFFF);
    add_cfg(dbls_pkg::CFG_FIRST_PASS_END, 16'd0);
    add_beat(1'b1, 1'b0, HELD_ZERO);
    add_beat(1'b1, 1'b0, HELD_ZERO);
    add_beat(1'b0, 1'b0, HELD_ZERO);
    add_beat(1'b1, 1'b0, HELD_ZERO);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < stim_rows.size(); i++) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        if (i == 0 || stim_rows[i-1].kind != ROW_CFG) settle();
        cfg_write(stim_rows[i].idx, stim_rows[i].data);
        if (i + 1 == stim_rows.size() || stim_rows[i+1].kind != ROW_CFG)
          cfg_ch.valid <= 1'b0;
      end else begin
        push_tick(stim_rows[i].tick, stim_rows[i].typed, stim_rows[i].want);
      end
    end

    // Start delay on B's first pass, which ends at phase 200; A stays below 2*peak.
    configure(16'd1, 16'd320, 16'd140, 16'd30, 16'd200);
    random_ticks(300, 120);

    // Wide ramp: a peak of 600 lets widths pass 255.
    src_idle_pct = 63;
    snk_idle_pct = 36;
    configure(16'd1, 16'd1000, 16'd600, 16'd0, 16'd0);
    random_ticks(300, 200);

    // No random idling from here. Cycle length below both phases: they keep counting
    // upward and the cycle length does not pull them back.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    configure(16'd1, 16'd5, 16'd2, 16'h8000, 16'd3);
    random_ticks(260, 30);

    // Zero step count: the divider only matches after its own 8-bit wrap.
    configure(16'd0, 16'd40, 16'd15, 16'd10, 16'd20);
    random_ticks(240, 50);

    // Largest step count.
    configure(16'd255, 16'd3, 16'd32767, 16'd65535, 16'd65535);
    random_ticks(240, -1);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/dbls_pkg.sv
src/dbls_if.sv
src/dual_breathing_led_duty_sequencer_core.sv
test/tb_top.sv
